[src/ltc_pkg.sv]
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared constants, field widths and operation codes of the LRU/TTL cache
// policy block.
// ----------------------------------------------------------------------------
package ltc_pkg;

  localparam int TABLE_DEPTH    = 64;
  localparam int SLOT_W         = $clog2(TABLE_DEPTH);
  localparam int COUNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_OVERHEAD = 96;

  localparam int KEY_W     = 64;
  localparam int TIME_W    = 64;
  localparam int TTL_W     = 32;
  localparam int KB_W      = 13;
  localparam int VB_W      = 27;
  localparam int SIZE_W    = 28;
  localparam int BYTES_W   = 36;
  localparam int DELTA_W   = 46;
  localparam int EV_W      = 7;
  localparam int META_W    = TTL_W + 1 + SIZE_W;
  localparam int CFG_W     = 36;

  localparam logic [13:0]     TICKS_PER_MS = 14'd10000;
  localparam logic [KB_W-1:0] KEY_LIMIT    = 13'd4096;
  localparam logic [VB_W-1:0] VALUE_LIMIT  = 27'd104857600;

  // operation codes
  localparam logic [2:0] OP_PUT      = 3'd0;
  localparam logic [2:0] OP_GET      = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_CONTAINS = 3'd3;
  localparam logic [2:0] OP_SWEEP    = 3'd4;
  localparam logic [2:0] OP_CLEAR    = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EXPIRED   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_EXP_OVF   = 3'd5;

  // configuration register indexes
  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_MAX_BYTES   = 1'b1;

endpackage

[src/ltc_ram.sv]
// ----------------------------------------------------------------------------
// ltc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, valid in the cycle after the read address.
// ----------------------------------------------------------------------------
module ltc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/lru_ttl_cache_policy.sv]
// ----------------------------------------------------------------------------
// lru_ttl_cache_policy
// Tag-and-policy engine of a key/value cache with LRU replacement and TTL
// expiry. Slot data lives in RAMs; recency is kept as a rank-ordered slot list.
// ----------------------------------------------------------------------------
// Work: contains/missing get/remove run one 64-slot lookup scan; hits add
//   a recency rotate over the ranks ahead of the entry; drops add a list
//   compaction over the entries; puts may add evictions while over a limit.
// Sweep: a full slot scan plus compaction plus evictions.
// Flow: one transaction at a time; the next is taken once the result is
//   registered. Reset clears valid bits, counters and limits.
// ----------------------------------------------------------------------------
module lru_ttl_cache_policy (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [ltc_pkg::CFG_W-1:0]     cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    kind,
  input  logic [ltc_pkg::KEY_W-1:0]     key_id,
  input  logic [ltc_pkg::KB_W-1:0]      key_bytes,
  input  logic [ltc_pkg::VB_W-1:0]      value_bytes,
  input  logic [ltc_pkg::TTL_W-1:0]     ttl_ms,
  input  logic                          sliding,
  input  logic [ltc_pkg::TIME_W-1:0]    now_ticks,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [ltc_pkg::SLOT_W-1:0]    slot,
  output logic [ltc_pkg::COUNT_W-1:0]   entry_count,
  output logic [ltc_pkg::BYTES_W-1:0]   total_bytes,
  output logic [ltc_pkg::EV_W-1:0]      evicted_count
);

  import ltc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_PUT_MUL, S_PUT_CHK, S_PUT_RECHK, S_LOOK, S_LOOK_END,
    S_GET_MUL, S_GET_RENEW, S_PUT_FULLDONE, S_PUT_WRITE, S_ROT_RD, S_ROT_WR,
    S_CMP_RD, S_CMP_WR, S_SW_RD, S_SW_WR, S_EV_CHK, S_EV_A, S_EV_B, S_DONE
  } state_t;

  state_t state;
  state_t ev_ret;

  // configuration
  logic [COUNT_W-1:0] max_entries;
  logic [BYTES_W-1:0] max_bytes;

  // policy state kept in flops
  logic [TABLE_DEPTH-1:0] entry_valid;
  logic [COUNT_W-1:0]     count;
  logic [BYTES_W-1:0]     total;

  // latched transaction
  logic [2:0]         kind_r;
  logic [KEY_W-1:0]   key_r;
  logic [KB_W-1:0]    kb_r;
  logic [VB_W-1:0]    vb_r;
  logic [TTL_W-1:0]   ttl_r;
  logic               sl_r;
  logic [TIME_W-1:0]  now_r;

  // working registers
  logic [DELTA_W-1:0] delta;
  logic [SIZE_W-1:0]  size_r;
  logic [2:0]         st_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [EV_W-1:0]    ev;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] wptr;
  logic [COUNT_W-1:0] cend;
  logic [COUNT_W-1:0] rot_end;
  logic               rot_stop;
  logic [SLOT_W-1:0]  rot_slot;
  logic [SLOT_W-1:0]  carry;
  logic [SLOT_W-1:0]  victim;
  logic               ev_force;
  logic               look_v;
  logic [SLOT_W-1:0]  look_idx;
  logic               found;
  logic [SLOT_W-1:0]  fslot;
  logic [TIME_W-1:0]  fexp;
  logic [TTL_W-1:0]   fttl;
  logic               fsl;
  logic [SIZE_W-1:0]  fsize;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;

  // RAM ports
  logic [SLOT_W-1:0]  slot_raddr;
  logic [SLOT_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0]  exp_waddr;
  logic               key_we;
  logic               exp_we;
  logic [KEY_W-1:0]   key_rdata;
  logic [TIME_W-1:0]  exp_rdata;
  logic [META_W-1:0]  meta_rdata;
  logic [SLOT_W-1:0]  order_raddr;
  logic [SLOT_W-1:0]  order_waddr;
  logic [SLOT_W-1:0]  order_wdata;
  logic               order_we;
  logic [SLOT_W-1:0]  order_rdata;

  logic [SIZE_W-1:0]  m_size;
  logic [TTL_W-1:0]   m_ttl;
  logic               m_sl;

  // derived values
  logic [TIME_W:0]    exp_sum;
  logic               exp_ovf;
  logic [DELTA_W-1:0] mul_src_ext;
  logic [TTL_W-1:0]   mul_src;
  logic [BYTES_W:0]   total_plus_size;
  logic [BYTES_W:0]   total_swap_size;
  logic [COUNT_W-1:0] lim;
  logic               over_limits;
  logic [COUNT_W-1:0] count_m1;

  assign m_size = meta_rdata[SIZE_W-1:0];
  assign m_sl   = meta_rdata[SIZE_W];
  assign m_ttl  = meta_rdata[META_W-1 -: TTL_W];

  assign exp_sum = {1'b0, now_r} + {{(TIME_W + 1 - DELTA_W){1'b0}}, delta};
  assign exp_ovf = exp_sum[TIME_W];

  assign mul_src     = (state == S_PUT_MUL) ? ttl_r : fttl;
  assign mul_src_ext = mul_src * TICKS_PER_MS;

  assign total_plus_size = {1'b0, total} + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size_r};
  assign total_swap_size = {1'b0, total} - {{(BYTES_W + 1 - SIZE_W){1'b0}}, fsize}
                         + {{(BYTES_W + 1 - SIZE_W){1'b0}}, size_r};

  assign lim = (max_entries > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : max_entries;
  assign over_limits = ((lim != '0) && (count > lim)) ||
                       ((max_bytes != '0) && (total > max_bytes));
  assign count_m1 = count - COUNT_W'(1);

  assign in_ready = (state == S_IDLE);

  // RAM address and write selection
  always_comb begin
    slot_raddr  = (state == S_EV_A) ? order_rdata : idx[SLOT_W-1:0];
    order_raddr = (state == S_EV_CHK) ? count_m1[SLOT_W-1:0] : idx[SLOT_W-1:0];
    key_we      = (state == S_PUT_WRITE);
    slot_waddr  = rot_slot;
    exp_we      = (state == S_PUT_WRITE) || ((state == S_GET_RENEW) && !exp_ovf);
    exp_waddr   = (state == S_PUT_WRITE) ? rot_slot : fslot;
    order_we    = 1'b0;
    order_waddr = idx[SLOT_W-1:0];
    order_wdata = carry;
    case (state)
      S_ROT_RD: order_we = !rot_stop && (idx == rot_end);
      S_ROT_WR: order_we = 1'b1;
      S_CMP_WR: begin
        order_we    = entry_valid[order_rdata];
        order_waddr = wptr[SLOT_W-1:0];
        order_wdata = order_rdata;
      end
      default: order_we = 1'b0;
    endcase
  end

  ltc_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(slot_waddr), .wdata(key_r),
    .raddr(slot_raddr), .rdata(key_rdata)
  );

  ltc_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_DEPTH)) u_exp_ram (
    .clk(clk), .we(exp_we), .waddr(exp_waddr), .wdata(exp_sum[TIME_W-1:0]),
    .raddr(slot_raddr), .rdata(exp_rdata)
  );

  ltc_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta_ram (
    .clk(clk), .we(key_we), .waddr(slot_waddr), .wdata({ttl_r, sl_r, size_r}),
    .raddr(slot_raddr), .rdata(meta_rdata)
  );

  // slot per recency rank, rank 0 first
  ltc_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_order_ram (
    .clk(clk), .we(order_we), .waddr(order_waddr), .wdata(order_wdata),
    .raddr(order_raddr), .rdata(order_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ev_ret      <= S_DONE;
      max_entries <= '0;
      max_bytes   <= '0;
      entry_valid <= '0;
      count       <= '0;
      total       <= '0;
      out_valid   <= 1'b0;
      look_v      <= 1'b0;
      ev_force    <= 1'b0;
    end else begin
      // the user must write configuration only while idle; the block does not enforce it
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_MAX_ENTRIES: max_entries <= cfg_data[COUNT_W-1:0];
          CFG_MAX_BYTES:   max_bytes   <= cfg_data[BYTES_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // lookup pipeline: look_v and look_idx are registered alongside the RAM read data
      look_v   <= (state == S_LOOK) && (idx != COUNT_W'(TABLE_DEPTH));
      look_idx <= idx[SLOT_W-1:0];
      if (look_v) begin
        if (entry_valid[look_idx] && (key_rdata == key_r) && !found) begin
          found <= 1'b1;
          fslot <= look_idx;
          fexp  <= exp_rdata;
          fttl  <= m_ttl;
          fsl   <= m_sl;
          fsize <= m_size;
        end
        if (!entry_valid[look_idx] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= look_idx;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r     <= kind;
            key_r      <= key_id;
            kb_r       <= key_bytes;
            vb_r       <= value_bytes;
            ttl_r      <= ttl_ms;
            sl_r       <= sliding;
            now_r      <= now_ticks;
            st_r       <= ST_OK;
            slot_r     <= '0;
            ev         <= '0;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            ev_force   <= 1'b0;
            case (kind)
              OP_PUT: state <= S_PUT_MUL;
              OP_GET, OP_REMOVE, OP_CONTAINS: state <= S_LOOK;
              OP_SWEEP: begin
                cend  <= count;
                state <= S_SW_RD;
              end
              OP_CLEAR: begin
                entry_valid <= '0;
                count       <= '0;
                total       <= '0;
                state       <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end

        S_PUT_MUL: begin
          delta  <= mul_src_ext[DELTA_W-1:0];
          size_r <= {{(SIZE_W - KB_W){1'b0}}, kb_r} + {{(SIZE_W - VB_W){1'b0}}, vb_r}
                  + SIZE_W'(ENTRY_OVERHEAD);
          if ((kb_r == '0) || (kb_r > KEY_LIMIT) || (vb_r > VALUE_LIMIT)) begin
            st_r  <= ST_TOO_LARGE;
            state <= S_DONE;
          end else begin
            state <= S_PUT_CHK;
          end
        end

        S_PUT_CHK: begin
          if (exp_ovf) begin
            st_r  <= ST_EXP_OVF;
            state <= S_DONE;
          end else if ((max_bytes != '0) && (total_plus_size > {1'b0, max_bytes})) begin
            ev_ret <= S_PUT_RECHK;
            state  <= S_EV_CHK;
          end else begin
            state <= S_LOOK;
          end
        end

        S_PUT_RECHK: begin
          if (total_plus_size > {1'b0, max_bytes}) begin
            st_r  <= ST_FULL;
            state <= S_DONE;
          end else begin
            state <= S_LOOK;
          end
        end

        // scan every slot for the key and the lowest free slot
        S_LOOK: begin
          if (idx == COUNT_W'(TABLE_DEPTH)) begin
            state <= S_LOOK_END;
          end else begin
            idx <= idx + COUNT_W'(1);
          end
        end

        S_LOOK_END: begin
          idx  <= '0;
          wptr <= '0;
          case (kind_r)
            OP_PUT: begin
              if (found) begin
                if (total_swap_size[BYTES_W]) begin
                  st_r  <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  // release the old copy; its rank is reused by the rotate
                  entry_valid[fslot] <= 1'b0;
                  total    <= total - {{(BYTES_W - SIZE_W){1'b0}}, fsize};
                  count    <= count_m1;
                  rot_slot <= fslot;
                  rot_stop <= 1'b1;
                  state    <= S_PUT_WRITE;
                end
              end else if (total_plus_size[BYTES_W]) begin
                st_r  <= ST_FULL;
                state <= S_DONE;
              end else if (count == COUNT_W'(TABLE_DEPTH)) begin
                // full table: evict the oldest, then reuse its slot
                ev_force <= 1'b1;
                ev_ret   <= S_PUT_FULLDONE;
                state    <= S_EV_CHK;
              end else begin
                rot_slot <= free_slot;
                rot_stop <= 1'b0;
                state    <= S_PUT_WRITE;
              end
            end
            OP_GET: begin
              if (!found) begin
                st_r  <= ST_NOT_FOUND;
                state <= S_DONE;
              end else if (fexp <= now_r) begin
                slot_r <= fslot;
                entry_valid[fslot] <= 1'b0;
                total  <= total - {{(BYTES_W - SIZE_W){1'b0}}, fsize};
                count  <= count_m1;
                cend   <= count;
                ev     <= EV_W'(1);
                st_r   <= ST_EXPIRED;
                state  <= S_CMP_RD;
              end else begin
                slot_r   <= fslot;
                rot_slot <= fslot;
                rot_stop <= 1'b1;
                carry    <= fslot;
                state    <= (fsl && (fttl != '0)) ? S_GET_MUL : S_ROT_RD;
              end
            end
            OP_REMOVE: begin
              if (!found) begin
                st_r  <= ST_NOT_FOUND;
                state <= S_DONE;
              end else begin
                slot_r <= fslot;
                entry_valid[fslot] <= 1'b0;
                total  <= total - {{(BYTES_W - SIZE_W){1'b0}}, fsize};
                count  <= count_m1;
                cend   <= count;
                state  <= S_CMP_RD;
              end
            end
            default: begin
              if (!found) begin
                st_r <= ST_NOT_FOUND;
              end else begin
                slot_r <= fslot;
                st_r   <= (fexp <= now_r) ? ST_EXPIRED : ST_OK;
              end
              state <= S_DONE;
            end
          endcase
        end

        S_GET_MUL: begin
          delta <= mul_src_ext[DELTA_W-1:0];
          state <= S_GET_RENEW;
        end

        // expiry write happens here when the renewed time fits
        S_GET_RENEW: state <= S_ROT_RD;

        S_PUT_FULLDONE: begin
          rot_slot <= victim;
          rot_stop <= 1'b0;
          state    <= S_PUT_WRITE;
        end

        S_PUT_WRITE: begin
          entry_valid[rot_slot] <= 1'b1;
          count   <= count + COUNT_W'(1);
          total   <= total + {{(BYTES_W - SIZE_W){1'b0}}, size_r};
          slot_r  <= rot_slot;
          rot_end <= count;
          carry   <= rot_slot;
          idx     <= '0;
          state   <= S_ROT_RD;
        end

        // move the slot to rank 0, shifting younger ranks down one place
        S_ROT_RD: begin
          if (!rot_stop && (idx == rot_end)) begin
            if (kind_r == OP_PUT) begin
              ev_ret <= S_DONE;
              state  <= S_EV_CHK;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_ROT_WR;
          end
        end

        S_ROT_WR: begin
          carry <= order_rdata;
          idx   <= idx + COUNT_W'(1);
          if (rot_stop && (order_rdata == rot_slot)) begin
            if (kind_r == OP_PUT) begin
              ev_ret <= S_DONE;
              state  <= S_EV_CHK;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_ROT_RD;
          end
        end

        // squeeze dropped slots out of the rank list
        S_CMP_RD: begin
          if (idx == cend) begin
            if (kind_r == OP_SWEEP) begin
              ev_ret <= S_DONE;
              state  <= S_EV_CHK;
            end else begin
              state <= S_DONE;
            end
          end else begin
            state <= S_CMP_WR;
          end
        end

        S_CMP_WR: begin
          if (entry_valid[order_rdata]) begin
            wptr <= wptr + COUNT_W'(1);
          end
          idx   <= idx + COUNT_W'(1);
          state <= S_CMP_RD;
        end

        S_SW_RD: state <= S_SW_WR;

        S_SW_WR: begin
          if (entry_valid[idx[SLOT_W-1:0]] && (exp_rdata <= now_r)) begin
            entry_valid[idx[SLOT_W-1:0]] <= 1'b0;
            total <= total - {{(BYTES_W - SIZE_W){1'b0}}, m_size};
            count <= count_m1;
            ev    <= (ev == '1) ? ev : ev + EV_W'(1);
          end
          if (idx == COUNT_W'(TABLE_DEPTH - 1)) begin
            idx   <= '0;
            wptr  <= '0;
            state <= S_CMP_RD;
          end else begin
            idx   <= idx + COUNT_W'(1);
            state <= S_SW_RD;
          end
        end

        // evict the oldest entry while over a limit or when forced; survivors keep ranks
        S_EV_CHK: begin
          if ((count != '0) && (ev_force || over_limits)) begin
            state <= S_EV_A;
          end else begin
            state <= ev_ret;
          end
        end

        S_EV_A: begin
          victim <= order_rdata;
          state  <= S_EV_B;
        end

        // a full-table eviction drops exactly one entry before the insert
        S_EV_B: begin
          entry_valid[victim] <= 1'b0;
          total    <= total - {{(BYTES_W - SIZE_W){1'b0}}, m_size};
          count    <= count_m1;
          ev       <= (ev == '1) ? ev : ev + EV_W'(1);
          ev_force <= 1'b0;
          state    <= ev_force ? ev_ret : S_EV_CHK;
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            status        <= st_r;
            slot          <= slot_r;
            entry_count   <= count;
            total_bytes   <= total;
            evicted_count <= ev;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
